// File: design/vertical_altitude_fusion_unit_defines.svh
// Assertion macros shared by the vertical altitude fusion RTL
`ifndef VERTICAL_ALTITUDE_FUSION_UNIT_DEFINES_SVH
`define VERTICAL_ALTITUDE_FUSION_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define VAFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define VAFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vafu_pkg.sv
// Types, constants and helpers of the vertical altitude fusion unit
`default_nettype none
package vafu_pkg;

  localparam int US_PER_S       = 1000000;
  localparam int COMP_THRESHOLD = 6554;
  localparam int ALPHA_MAX      = 327680;
  localparam int X_LIMIT        = 131072;
  localparam int FAST_DIV       = 5;
  localparam int SLOW_DIV       = 200;
  localparam int POS_DIV        = 10;
  localparam int ALPHA_DIV      = 65536;

  localparam logic OP_INERTIAL = 1'b0;
  localparam logic OP_BARO     = 1'b1;

  typedef enum logic [1:0] {
    REG_ORIGIN   = 2'd0,
    REG_STEP     = 2'd1,
    REG_DEADBAND = 2'd2
  } vafu_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_I0, ST_IV, ST_IP,
    ST_B0, ST_BF, ST_BS, ST_BA, ST_BM, ST_BC,
    ST_BK, ST_BR, ST_BW, ST_BV, ST_BP, ST_OUT
  } vafu_state_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic [31:0]        den;
  } vafu_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] quo;
  } vafu_div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// File: design/vafu_if.sv
// Input and result channel interfaces of the vertical altitude fusion unit
`default_nettype none
interface vafu_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] accel_z;
  logic signed [31:0] baro_altitude;
  logic [31:0]        elapsed_us;
  modport source (output valid, op, accel_z, baro_altitude, elapsed_us, input ready);
  modport sink (input valid, op, accel_z, baro_altitude, elapsed_us, output ready);
endinterface

interface vafu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertical_velocity;
  logic signed [31:0] vertical_position;
  logic signed [31:0] fused_altitude;
  modport source (output valid, vertical_velocity, vertical_position, fused_altitude,
                  input ready);
  modport sink (input valid, vertical_velocity, vertical_position, fused_altitude,
                output ready);
endinterface
`default_nettype wire

// File: design/vertical_altitude_fusion_unit.sv
// Vertical altitude fusion unit: top level with sequencer and datapath
//
// Fuses vertical acceleration (op 0) and barometric altitude (op 1), all in
// Q16.16. Each accepted input item yields exactly one result item carrying
// velocity, position and compensated altitude.
// Input and result channels use valid/ready; an item moves when both are high.
// The block works on one item at a time: in_ch.ready is high only while idle.
// Every division runs through one shared bit-serial divider that yields a
// 64-bit quotient. An inertial item costs two divisions; a barometer item
// four to seven, depending on the drift compensation and the climb-rate
// update. The result sits in an output register; the next item is accepted
// while it waits, and the sequencer only stalls at its final step if the
// receiver has still not taken the previous result. Configuration is
// written over the APB port; the user must do so only while idle, as the
// block does not enforce it. pready is tied high. A synchronous active-low
// reset restores register defaults and clears all filter state; no clearing
// pass is needed.
`default_nettype none
`include "vertical_altitude_fusion_unit_defines.svh"
module vertical_altitude_fusion_unit
  import vafu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  vafu_in_if.sink          in_ch,
  vafu_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  vafu_state_t state_r, state_nxt;

  logic signed [31:0] origin_r;
  logic [15:0]        step_r, dband_r;
  logic signed [31:0] fa_r, v_r, p_r, fast_r, slow_r, prev_r, climb_r;
  logic               seen_r;
  logic signed [31:0] a_r, b_r;
  logic [31:0]        el_r;
  logic [16:0]        x_r;
  logic [18:0]        alpha_r;
  logic signed [63:0] num_r;
  logic [31:0]        den_r;
  logic               start_r;
  logic               out_valid_r;
  logic signed [31:0] out_v_r, out_p_r, out_alt_r;

  vafu_div_req_t div_req;
  vafu_div_rsp_t div_rsp;

  logic               in_acc, cfg_wr, load_out, done;
  logic signed [32:0] s_sum, db, dband_s, dsub, fs, dh;
  logic signed [31:0] avg, vn, quo_lo;
  logic signed [16:0] step_s;
  logic [32:0]        dabs, xw;
  logic               comp, x_big, climb_go;
  logic [19:0]        a_sum;

  vafu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Datapath arithmetic shared by the sequencer steps
  always_comb begin
    done     = div_rsp.done;
    quo_lo   = div_rsp.quo[31:0];
    s_sum    = 33'(fa_r) + 33'(a_r);
    avg      = s_sum[32:1];
    dband_s  = $signed({17'd0, dband_r});
    step_s   = $signed({1'b0, step_r});
    if (33'(avg) > dband_s) begin
      db = 33'(avg) - dband_s;
    end else if (33'(avg) < -dband_s) begin
      db = 33'(avg) + dband_s;
    end else begin
      db = '0;
    end
    vn       = sat32(64'(v_r) + div_rsp.quo);
    dsub     = 33'(quo_lo) - 33'(fast_r);
    dabs     = dsub[32] ? 33'(-dsub) : 33'(dsub);
    comp     = dabs >= 33'(COMP_THRESHOLD);
    xw       = dabs - 33'(COMP_THRESHOLD);
    x_big    = xw >= 33'(X_LIMIT);
    a_sum    = 20'(div_rsp.quo[19:0]) + {2'b0, x_r, 1'b0};
    fs       = 33'(fast_r) - 33'(slow_r);
    dh       = 33'(slow_r) - 33'(prev_r);
    climb_go = seen_r && (el_r != 32'd0);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = (in_ch.op == OP_BARO) ? ST_B0 : ST_I0;
      ST_I0:   state_nxt = ST_IV;
      ST_IV:   if (done) state_nxt = ST_IP;
      ST_IP:   if (done) state_nxt = ST_OUT;
      ST_B0:   state_nxt = ST_BF;
      ST_BF:   if (done) state_nxt = ST_BS;
      ST_BS:   if (done) state_nxt = !comp ? ST_BK : (x_big ? ST_BM : ST_BA);
      ST_BA:   if (done) state_nxt = ST_BM;
      ST_BM:   state_nxt = ST_BC;
      ST_BC:   if (done) state_nxt = ST_BK;
      ST_BK:   state_nxt = climb_go ? ST_BR : ST_BW;
      ST_BR:   if (done) state_nxt = ST_BW;
      ST_BW:   state_nxt = ST_BV;
      ST_BV:   if (done) state_nxt = ST_BP;
      ST_BP:   if (done) state_nxt = ST_OUT;
      ST_OUT:  if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshakes and divider request
  always_comb begin
    in_ch.ready   = (state_r == ST_IDLE);
    in_acc        = in_ch.valid && in_ch.ready;
    load_out      = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
    cfg_wr        = psel && penable && pwrite;
    div_req.start = start_r;
    div_req.num   = num_r;
    div_req.den   = den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Filter state, step setup and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      step_r   <= 16'd1000;
      dband_r  <= 16'd2621;
      fa_r     <= '0;
      v_r      <= '0;
      p_r      <= '0;
      fast_r   <= '0;
      slow_r   <= '0;
      prev_r   <= '0;
      climb_r  <= '0;
      seen_r   <= 1'b0;
      start_r  <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_ORIGIN: begin
            origin_r <= pwdata;
            if (!seen_r) slow_r <= pwdata;
          end
          REG_STEP:     step_r  <= pwdata[15:0];
          REG_DEADBAND: dband_r <= pwdata[15:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: if (in_acc) begin
          a_r  <= in_ch.accel_z;
          b_r  <= in_ch.baro_altitude;
          el_r <= in_ch.elapsed_us;
        end
        ST_I0: begin
          fa_r    <= avg;
          num_r   <= 64'(db * step_s);
          den_r   <= 32'(US_PER_S);
          start_r <= 1'b1;
        end
        ST_IV: if (done) begin
          v_r     <= vn;
          num_r   <= 64'(vn * step_s);
          den_r   <= 32'(US_PER_S);
          start_r <= 1'b1;
        end
        ST_IP: if (done) p_r <= sat32(64'(p_r) + div_rsp.quo);
        ST_B0: begin
          num_r   <= 64'(fast_r) + 64'(b_r) * 64'sd4;
          den_r   <= 32'(FAST_DIV);
          start_r <= 1'b1;
        end
        ST_BF: if (done) begin
          fast_r  <= quo_lo;
          num_r   <= 64'(slow_r) * 64'sd199 + 64'(b_r);
          den_r   <= 32'(SLOW_DIV);
          start_r <= 1'b1;
        end
        ST_BS: if (done) begin
          slow_r <= quo_lo;
          // Drift compensation weight: clamp at once or square it
          if (comp && x_big) begin
            alpha_r <= 19'(ALPHA_MAX);
          end else if (comp) begin
            x_r     <= xw[16:0];
            num_r   <= 64'(64'(xw[16:0]) * 64'(xw[16:0]));
            den_r   <= 32'(ALPHA_DIV);
            start_r <= 1'b1;
          end
        end
        ST_BA: if (done) begin
          alpha_r <= (a_sum > 20'(ALPHA_MAX)) ? 19'(ALPHA_MAX) : a_sum[18:0];
        end
        ST_BM: begin
          num_r   <= 64'($signed({1'b0, alpha_r}) * fs);
          den_r   <= 32'(ALPHA_MAX);
          start_r <= 1'b1;
        end
        ST_BC: if (done) slow_r <= slow_r + quo_lo;
        ST_BK: begin
          prev_r <= slow_r;
          seen_r <= 1'b1;
          if (climb_go) begin
            num_r   <= 64'(dh) * 64'(US_PER_S);
            den_r   <= el_r;
            start_r <= 1'b1;
          end
        end
        ST_BR: if (done) climb_r <= sat32(div_rsp.quo);
        ST_BW: begin
          num_r   <= 64'(v_r) * 64'sd199 + 64'(climb_r);
          den_r   <= 32'(SLOW_DIV);
          start_r <= 1'b1;
        end
        ST_BV: if (done) begin
          v_r     <= quo_lo;
          num_r   <= 64'(p_r) * 64'sd9 + 64'(slow_r) - 64'(origin_r);
          den_r   <= 32'(POS_DIV);
          start_r <= 1'b1;
        end
        ST_BP: if (done) p_r <= sat32(div_rsp.quo);
        default: ;
      endcase
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_v_r   <= v_r;
      out_p_r   <= p_r;
      out_alt_r <= slow_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.vertical_velocity = out_v_r;
  assign out_ch.vertical_position = out_p_r;
  assign out_ch.fused_altitude    = out_alt_r;

  // Register read-back
  always_comb begin
    pready = 1'b1;
    unique case (paddr[3:2])
      REG_ORIGIN:   prdata = origin_r;
      REG_STEP:     prdata = {16'd0, step_r};
      REG_DEADBAND: prdata = {16'd0, dband_r};
      default:      prdata = '0;
    endcase
  end

  `VAFU_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != ST_IDLE, "item accepted but sequencer stayed idle")
  `VAFU_ASSERT_NOW(a_start_when_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `VAFU_ASSERT_NOW(a_done_in_wait, div_rsp.done, state_r == ST_IV || state_r == ST_IP || state_r == ST_BF || state_r == ST_BS || state_r == ST_BA || state_r == ST_BC || state_r == ST_BR || state_r == ST_BV || state_r == ST_BP, "quotient arrived outside a wait step")
  `VAFU_ASSERT_NEXT(a_out_loaded, load_out, out_valid_r, "result load did not raise valid")

endmodule
`default_nettype wire

// File: design/vafu_div.sv
// Bit-serial signed divider, rounding to nearest with ties away from zero
`default_nettype none
module vafu_div
  import vafu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  vafu_div_req_t req,
  output vafu_div_rsp_t rsp
);

  logic               busy_r, done_r, neg_r;
  logic [5:0]         cnt_r;
  logic [63:0]        dvd_r;
  logic [31:0]        rem_r;
  logic [31:0]        den_r;
  logic [63:0]        mag;
  logic [32:0]        trial;
  logic               fits;

  // Magnitude plus half divisor gives the rounded quotient
  always_comb begin
    mag   = (req.num[63] ? 64'(-req.num) : 64'(req.num)) + 64'(req.den >> 1);
    trial = {rem_r, dvd_r[63]};
    fits  = trial >= {1'b0, den_r};
  end

  // Shift one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= mag;
        rem_r  <= '0;
        den_r  <= req.den;
        neg_r  <= req.num[63];
      end else if (busy_r) begin
        rem_r <= fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];
        dvd_r <= {dvd_r[62:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? -$signed(dvd_r) : $signed(dvd_r);

endmodule
`default_nettype wire
